// ===== rtl/atpr_pkg.sv =====
// ----------------------------------------------------------------------------
// atpr_pkg - tilt pitch/roll shared definitions
// Fixed-point formats, CORDIC arctangent table and angle finishing for the
// accelerometer tilt pipeline.
// ----------------------------------------------------------------------------
package atpr_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int SAMPLE_WIDTH_DEF  = 16;

	localparam int TBL_LEN    = 24;
	localparam int IN_W       = 16;
	localparam int SMP_W      = 17;   // sign-extended or zero-extended sample
	localparam int GUARD_BITS = 24;
	localparam int VEC_W      = 46;   // vector component, sample * 2^24 plus growth
	localparam int ACC_W      = 33;   // hundredths of a degree * 2^16
	localparam int ANG_FRAC   = 16;
	localparam int ANG_W      = 16;
	localparam int PITCH_W    = 15;

	localparam logic signed [25:0]      GAIN_Q24      = 26'sd27628053;
	localparam logic signed [ANG_W-1:0] HALF_TURN     = 16'sd18000;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN  = 16'sd9000;
	localparam logic signed [ACC_W-1:0] ACC_HALF_TURN = 33'sd1179648000;
	localparam logic signed [ACC_W-1:0] ROUND_HALF    = 33'sd32768;

	typedef struct packed {
		logic signed [VEC_W-1:0] a;
		logic signed [VEC_W-1:0] b;
		logic signed [ACC_W-1:0] acc;
	} cordic_vec_t;

	// round(atan(2^-i) deg * 100 * 2^16)
	function automatic logic signed [ACC_W-1:0] atan_q16(input logic [4:0] idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			5'd0:    v = 33'sd294912000;
			5'd1:    v = 33'sd174096719;
			5'd2:    v = 33'sd91987925;
			5'd3:    v = 33'sd46694507;
			5'd4:    v = 33'sd23437865;
			5'd5:    v = 33'sd11730358;
			5'd6:    v = 33'sd5866610;
			5'd7:    v = 33'sd2933484;
			5'd8:    v = 33'sd1466764;
			5'd9:    v = 33'sd733385;
			5'd10:   v = 33'sd366693;
			5'd11:   v = 33'sd183346;
			5'd12:   v = 33'sd91673;
			5'd13:   v = 33'sd45837;
			5'd14:   v = 33'sd22918;
			5'd15:   v = 33'sd11459;
			5'd16:   v = 33'sd5730;
			5'd17:   v = 33'sd2865;
			5'd18:   v = 33'sd1432;
			5'd19:   v = 33'sd716;
			5'd20:   v = 33'sd358;
			5'd21:   v = 33'sd179;
			5'd22:   v = 33'sd90;
			5'd23:   v = 33'sd45;
			default: v = '0;
		endcase
		return v;
	endfunction

	// round half up to hundredths, clamp to +/-lim
	function automatic logic signed [ANG_W-1:0] finish_angle(
		input logic signed [ACC_W-1:0] acc,
		input logic signed [ANG_W-1:0] lim
	);
		logic signed [ACC_W-1:0] sum;
		logic signed [ACC_W-1:0] r;
		logic signed [ACC_W-1:0] lim_x;
		sum   = acc + ROUND_HALF;
		r     = sum >>> ANG_FRAC;
		lim_x = ACC_W'(lim);
		if (r > lim_x)
			r = lim_x;
		if (r < -lim_x)
			r = -lim_x;
		return r[ANG_W-1:0];
	endfunction

endpackage

// ===== rtl/atpr_cordic_pass.sv =====
// ----------------------------------------------------------------------------
// atpr_cordic_pass - pipelined CORDIC vectoring pass
// One register stage per micro-rotation; drives b towards zero, accumulates
// the turned angle and carries a sideband word alongside.
// ----------------------------------------------------------------------------
module atpr_cordic_pass #(
	parameter int NUM_STAGES = atpr_pkg::CORDIC_STAGES_DEF,
	parameter int SIDE_W     = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  atpr_pkg::cordic_vec_t  in_vec,
	input  logic [SIDE_W-1:0]      in_side,
	output logic                   out_valid,
	output atpr_pkg::cordic_vec_t  out_vec,
	output logic [SIDE_W-1:0]      out_side
);

	atpr_pkg::cordic_vec_t vec_s  [0:NUM_STAGES-1];
	logic [SIDE_W-1:0]     side_s [0:NUM_STAGES-1];
	logic                  vld_s  [0:NUM_STAGES-1];

	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
		atpr_pkg::cordic_vec_t src;
		atpr_pkg::cordic_vec_t nxt;
		logic                  src_vld;
		logic [SIDE_W-1:0]     src_side;

		if (i == 0) begin : g_first
			assign src      = in_vec;
			assign src_vld  = in_valid;
			assign src_side = in_side;
		end else begin : g_next
			assign src      = vec_s[i-1];
			assign src_vld  = vld_s[i-1];
			assign src_side = side_s[i-1];
		end

		always_comb begin
			logic signed [atpr_pkg::VEC_W-1:0] da;
			logic signed [atpr_pkg::VEC_W-1:0] db;
			da = src.b >>> i;
			db = src.a >>> i;
			if (!src.b[atpr_pkg::VEC_W-1]) begin
				nxt.a   = src.a + da;
				nxt.b   = src.b - db;
				nxt.acc = src.acc + atpr_pkg::atan_q16(5'(i));
			end else begin
				nxt.a   = src.a - da;
				nxt.b   = src.b + db;
				nxt.acc = src.acc - atpr_pkg::atan_q16(5'(i));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i] <= 1'b0;
			else
				vld_s[i] <= src_vld;
		end

		always_ff @(posedge clk) begin
			if (src_vld) begin
				vec_s[i]  <= nxt;
				side_s[i] <= src_side;
			end
		end
	end

	assign out_valid = vld_s[NUM_STAGES-1];
	assign out_vec   = vec_s[NUM_STAGES-1];
	assign out_side  = side_s[NUM_STAGES-1];

endmodule

// ===== rtl/accel_tilt_pitch_roll_unit.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll_unit - accelerometer tilt to pitch and roll
// Roll = atan2(y, z), pitch = atan2(-x, hypot(y, z)) in hundredths of a
// degree, via two chained pipelined CORDIC vectoring passes.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: accel_x/y/z, taken on a clock edge with start high and busy
//   low. busy is always low; a new word may be offered every cycle.
//   Result word: pitch_angle and roll_angle, valid for the single cycle in
//   which done is high. There is no back-pressure; the receiver must take
//   every word as it appears.
//   Pipeline: N = min(CORDIC_STAGES, 24) micro-rotations in each pass, with
//   one register stage per CORDIC micro-rotation, plus an input stage, a
//   middle stage (roll rounding, -x * gain product) and an output stage.
//   Throughput is one word per cycle.
//   Results come out in accept order, one per input word.
//   Reset: arst_n clears every valid bit at once; words in flight are
//   dropped and done stays low until new words reach the output.
//   Zero vectors give zero angles; angles are rounded and clamped to range.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll_unit #(
	parameter int CORDIC_STAGES = atpr_pkg::CORDIC_STAGES_DEF,
	parameter int SAMPLE_WIDTH  = atpr_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [atpr_pkg::IN_W-1:0]    accel_x,
	input  logic signed [atpr_pkg::IN_W-1:0]    accel_y,
	input  logic signed [atpr_pkg::IN_W-1:0]    accel_z,
	output logic                                done,
	output logic signed [atpr_pkg::PITCH_W-1:0] pitch_angle,
	output logic signed [atpr_pkg::ANG_W-1:0]   roll_angle
);

	localparam int NUM_STAGES = (CORDIC_STAGES > atpr_pkg::TBL_LEN) ?
		atpr_pkg::TBL_LEN : CORDIC_STAGES;
	localparam int SIGN_POS = (SAMPLE_WIDTH > atpr_pkg::IN_W) ?
		atpr_pkg::IN_W : SAMPLE_WIDTH - 1;
	localparam int SMP_W  = atpr_pkg::SMP_W;
	localparam int VEC_W  = atpr_pkg::VEC_W;
	localparam int ACC_W  = atpr_pkg::ACC_W;
	localparam int ANG_W  = atpr_pkg::ANG_W;
	localparam int SIDE1_W = SMP_W + 1;
	localparam int SIDE2_W = ANG_W + 1;
	localparam int LAT    = 2 * NUM_STAGES + 3;
	localparam int CNT_W  = $clog2(LAT + 2);

	function automatic logic signed [SMP_W-1:0] sample_of(input logic [atpr_pkg::IN_W-1:0] raw);
		logic [SMP_W-1:0]        rx;
		logic signed [SMP_W-1:0] s;
		rx = {1'b0, raw};
		for (int k = 0; k < SMP_W; k++)
			s[k] = (k <= SIGN_POS) ? rx[k] : rx[SIGN_POS];
		return s;
	endfunction

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// input stage: sample extraction and half-turn pre-rotation
	logic signed [SMP_W-1:0] x_in, y_in, z_in;
	logic signed [VEC_W-1:0] a_in, b_in;
	atpr_pkg::cordic_vec_t   vec_in;

	always_comb begin
		x_in = sample_of(accel_x);
		y_in = sample_of(accel_y);
		z_in = sample_of(accel_z);
		a_in = VEC_W'(z_in) <<< atpr_pkg::GUARD_BITS;
		b_in = VEC_W'(y_in) <<< atpr_pkg::GUARD_BITS;
		if (z_in[SMP_W-1]) begin
			vec_in.a   = -a_in;
			vec_in.b   = -b_in;
			vec_in.acc = y_in[SMP_W-1] ? -atpr_pkg::ACC_HALF_TURN : atpr_pkg::ACC_HALF_TURN;
		end else begin
			vec_in.a   = a_in;
			vec_in.b   = b_in;
			vec_in.acc = '0;
		end
	end

	logic                    vld_s1;
	atpr_pkg::cordic_vec_t   vec_s1;
	logic signed [SMP_W-1:0] x_s1;
	logic                    zero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vec_s1  <= vec_in;
			x_s1    <= x_in;
			zero_s1 <= (y_in == '0) && (z_in == '0);
		end
	end

	// roll pass
	logic                   p1_vld;
	atpr_pkg::cordic_vec_t  p1_vec;
	logic [SIDE1_W-1:0]     p1_side;

	atpr_cordic_pass #(
		.NUM_STAGES (NUM_STAGES),
		.SIDE_W     (SIDE1_W)
	) u_roll_pass (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_vec    (vec_s1),
		.in_side   ({zero_s1, x_s1}),
		.out_valid (p1_vld),
		.out_vec   (p1_vec),
		.out_side  (p1_side)
	);

	// middle stage: magnitude, roll rounding, -x * K
	logic                      p1_zero;
	logic signed [SMP_W-1:0]   p1_x;
	logic signed [SMP_W:0]     neg_x;
	logic signed [VEC_W-1:0]   mag;
	atpr_pkg::cordic_vec_t     vec_mid;
	logic signed [ANG_W-1:0]   roll_mid;

	always_comb begin
		p1_zero = p1_side[SMP_W];
		p1_x    = p1_side[SMP_W-1:0];
		neg_x   = -((SMP_W + 1)'(p1_x));
		mag     = (p1_zero || p1_vec.a[VEC_W-1]) ? '0 : p1_vec.a;
		vec_mid.a   = mag;
		vec_mid.b   = VEC_W'(neg_x) * VEC_W'(atpr_pkg::GAIN_Q24);
		vec_mid.acc = '0;
		roll_mid = p1_zero ? '0 : atpr_pkg::finish_angle(p1_vec.acc, atpr_pkg::HALF_TURN);
	end

	logic                    vld_s2;
	atpr_pkg::cordic_vec_t   vec_s2;
	logic signed [ANG_W-1:0] roll_s2;
	logic                    pen_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= p1_vld;
	end

	always_ff @(posedge clk) begin
		if (p1_vld) begin
			vec_s2  <= vec_mid;
			roll_s2 <= roll_mid;
			pen_s2  <= (p1_x != '0) || (mag != '0);
		end
	end

	// pitch pass
	logic                   p2_vld;
	atpr_pkg::cordic_vec_t  p2_vec;
	logic [SIDE2_W-1:0]     p2_side;

	atpr_cordic_pass #(
		.NUM_STAGES (NUM_STAGES),
		.SIDE_W     (SIDE2_W)
	) u_pitch_pass (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_vec    (vec_s2),
		.in_side   ({pen_s2, roll_s2}),
		.out_valid (p2_vld),
		.out_vec   (p2_vec),
		.out_side  (p2_side)
	);

	// output stage
	logic signed [ANG_W-1:0] pitch_out;

	always_comb begin
		if (p2_side[ANG_W])
			pitch_out = atpr_pkg::finish_angle(p2_vec.acc, atpr_pkg::QUARTER_TURN);
		else
			pitch_out = '0;
	end

	logic                                vld_s3;
	logic signed [atpr_pkg::PITCH_W-1:0] pitch_s3;
	logic signed [ANG_W-1:0]             roll_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= p2_vld;
	end

	always_ff @(posedge clk) begin
		if (p2_vld) begin
			pitch_s3 <= atpr_pkg::PITCH_W'(pitch_out);
			roll_s3  <= p2_side[ANG_W-1:0];
		end
	end

	assign done        = vld_s3;
	assign pitch_angle = pitch_s3;
	assign roll_angle  = roll_s3;

	// words in flight, for checking only
	logic [CNT_W-1:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else if (accept && !done)
			inflight_q <= inflight_q + CNT_W'(1);
		else if (!accept && done)
			inflight_q <= inflight_q - CNT_W'(1);
	end

	a_done_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> inflight_q != '0)
		else $error("result word with no word in flight");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(LAT + 1))
		else $error("more words in flight than pipeline depth");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (roll_angle <= atpr_pkg::HALF_TURN) && (roll_angle >= -atpr_pkg::HALF_TURN))
		else $error("roll out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ANG_W'(pitch_angle) <= atpr_pkg::QUARTER_TURN)
			&& (ANG_W'(pitch_angle) >= -atpr_pkg::QUARTER_TURN))
		else $error("pitch out of range");

	a_zero_roll: assert property (@(posedge clk) disable iff (!arst_n)
		(p1_vld && p1_zero) |=> roll_s2 == '0)
		else $error("zero y/z vector gave non-zero roll");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for accel_tilt_pitch_roll_unit
// Drives three-axis samples through the command interface and predicts pitch
// and roll with an independent two-pass CORDIC model. The model runs in 64-bit
// integers. A short table of directed words comes first, then random words in
// phases with different sender idle rates. Every done word is compared with
// the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int SW        = atpr_pkg::SAMPLE_WIDTH_DEF;
	localparam int STAGES    = (atpr_pkg::CORDIC_STAGES_DEF > 24) ? 24 :
	                           atpr_pkg::CORDIC_STAGES_DEF;
	localparam int LATENCY   = 2 * STAGES + 3;
	localparam int LIMIT     = 200000;
	localparam int RAND_WORDS = 700;
	localparam longint GAIN_Q24  = 64'sd27628053;
	localparam longint HALF_Q16  = 64'sd1179648000;
	localparam longint ROUND_Q16 = 64'sd32768;

	typedef logic signed [atpr_pkg::IN_W-1:0] axis_t;

	typedef struct packed {
		logic signed [atpr_pkg::PITCH_W-1:0] pitch;
		logic signed [atpr_pkg::ANG_W-1:0]   roll;
	} tilt_word_t;

	typedef struct packed {
		axis_t      x;
		axis_t      y;
		axis_t      z;
		logic       typed;
		tilt_word_t angles;
	} stim_row_t;

	logic  clk;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	axis_t accel_x = '0;
	axis_t accel_y = '0;
	axis_t accel_z = '0;
	logic  busy;
	logic  done;
	logic signed [atpr_pkg::PITCH_W-1:0] pitch_angle;
	logic signed [atpr_pkg::ANG_W-1:0]   roll_angle;

	tilt_word_t angles_due[$];
	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int cycle_count = 0;

	localparam int N_ROWS = 22;
	stim_row_t directed_rows [N_ROWS] = '{
		'{16'sd0,      16'sd0,      16'sd0,      1'b1, '{15'sd0,     16'sd0}},
		'{16'sd0,      16'sd0,      16'sd32767,  1'b1, '{15'sd0,     16'sd0}},
		'{16'sd0,      16'sd0,      16'sh8000,   1'b1, '{15'sd0,     16'sd18000}},
		'{16'sd0,      16'sd32767,  16'sd0,      1'b1, '{15'sd0,     16'sd9000}},
		'{16'sd0,      16'sh8000,   16'sd0,      1'b1, '{15'sd0,     -16'sd9000}},
		'{16'sd32767,  16'sd0,      16'sd0,      1'b1, '{-15'sd9000, 16'sd0}},
		'{16'sh8000,   16'sd0,      16'sd0,      1'b1, '{15'sd9000,  16'sd0}},
		'{16'sd0,      16'sd1,      -16'sd1,     1'b0, '0},
		'{16'sd0,      -16'sd1,     -16'sd1,     1'b0, '0},
		'{16'sd0,      16'sd0,      -16'sd1,     1'b0, '0},
		'{16'sd0,      -16'sd1,     16'sh8000,   1'b0, '0},
		'{-16'sd1,     16'sd0,      16'sd0,      1'b0, '0},
		'{16'sd1,      16'sd1,      16'sd1,      1'b0, '0},
		'{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, '0},
		'{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '0},
		'{16'sh8000,   16'sh8000,   16'sh8000,   1'b0, '0},
		'{16'sh8000,   16'sd32767,  16'sh8000,   1'b0, '0},
		'{16'sd32767,  16'sh8000,   16'sd32767,  1'b0, '0},
		'{16'sd100,    -16'sd200,   -16'sd300,   1'b0, '0},
		'{16'sh5555,   16'shAAAA,   16'sh5555,   1'b0, '0},
		'{16'shAAAA,   16'sh5555,   16'shAAAA,   1'b0, '0},
		'{16'sd12345,  -16'sd23456, -16'sd7,     1'b0, '0}
	};

	accel_tilt_pitch_roll_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.done        (done),
		.pitch_angle (pitch_angle),
		.roll_angle  (roll_angle)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint atan_step(input int i);
		longint v;
		case (i)
			0:  v = 294912000;
			1:  v = 174096719;
			2:  v = 91987925;
			3:  v = 46694507;
			4:  v = 23437865;
			5:  v = 11730358;
			6:  v = 5866610;
			7:  v = 2933484;
			8:  v = 1466764;
			9:  v = 733385;
			10: v = 366693;
			11: v = 183346;
			12: v = 91673;
			13: v = 45837;
			14: v = 22918;
			15: v = 11459;
			16: v = 5730;
			17: v = 2865;
			18: v = 1432;
			19: v = 716;
			20: v = 358;
			21: v = 179;
			22: v = 90;
			23: v = 45;
			default: v = 0;
		endcase
		return v;
	endfunction

	function automatic longint axis_value(input axis_t raw);
		longint s;
		s = longint'(raw);
		s = (s <<< (64 - SW)) >>> (64 - SW);
		return s;
	endfunction

	// drive b to zero, angle turned goes into acc
	function automatic void rotate_onto_axis(input longint a_in, input longint b_in,
			input longint acc_in, output longint a_out, output longint acc_out);
		longint a, b, acc, da, db;
		a = a_in;
		b = b_in;
		acc = acc_in;
		for (int i = 0; i < STAGES; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (b >= 0) begin
				a = a + da;
				b = b - db;
				acc = acc + atan_step(i);
			end else begin
				a = a - da;
				b = b + db;
				acc = acc - atan_step(i);
			end
		end
		a_out = a;
		acc_out = acc;
	endfunction

	function automatic longint round_clamp(input longint acc, input longint lim);
		longint r;
		r = (acc + ROUND_Q16) >>> 16;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic tilt_word_t tilt_predict(input axis_t xr, input axis_t yr,
			input axis_t zr);
		longint x, y, z, a, b, acc, mag, unused;
		tilt_word_t w;
		x = axis_value(xr);
		y = axis_value(yr);
		z = axis_value(zr);
		mag = 0;
		w = '0;
		if (y != 0 || z != 0) begin
			a = z <<< 24;
			b = y <<< 24;
			acc = 0;
			if (a < 0) begin
				acc = (b >= 0) ? HALF_Q16 : -HALF_Q16;
				a = -a;
				b = -b;
			end
			rotate_onto_axis(a, b, acc, mag, acc);
			if (mag < 0)
				mag = 0;
			w.roll = 16'(round_clamp(acc, 18000));
		end
		if (x != 0 || mag != 0) begin
			rotate_onto_axis(mag, -x * GAIN_Q24, 0, unused, acc);
			w.pitch = 15'(round_clamp(acc, 9000));
		end
		return w;
	endfunction

	task automatic send_word(input axis_t x, input axis_t y, input axis_t z,
			input logic typed, input tilt_word_t typed_angles);
		start   <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (typed)
			angles_due.push_back(typed_angles);
		else
			angles_due.push_back(tilt_predict(x, y, z));
		words_in++;
	endtask

	task automatic sender_gap(input int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_pipe;
		start <= 1'b0;
		@(posedge clk);
		while (angles_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic axis_t small_axis;
		return axis_t'(int'($urandom_range(32)) - 16);
	endfunction

	task automatic send_random(input int pct);
		axis_t x, y, z;
		int kind;
		x = axis_t'($urandom);
		y = axis_t'($urandom);
		z = axis_t'($urandom);
		kind = $urandom_range(99);
		if (kind >= 55 && kind < 70) begin
			x = small_axis();
			y = small_axis();
			z = small_axis();
		end else if (kind < 78 && kind >= 70) begin
			y = '0;
			z = '0;
		end else if (kind < 86 && kind >= 78) begin
			x = '0;
		end else if (kind < 92 && kind >= 86) begin
			// negative z on the half-turn seam
			y = ($urandom_range(1) != 0) ? axis_t'(0) : axis_t'(-1);
			z = axis_t'(-int'($urandom_range(32768, 1)));
		end else if (kind >= 92) begin
			// gravity-like: one dominant axis
			x = small_axis();
			y = small_axis();
			z = small_axis();
			case ($urandom_range(2))
				0: x = axis_t'($urandom);
				1: y = axis_t'($urandom);
				default: z = axis_t'($urandom);
			endcase
		end
		sender_gap(pct);
		send_word(x, y, z, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		tilt_word_t want;
		if (arst_n && done) begin
			if (angles_due.size() == 0) begin
				$display("%0t: unexpected word pitch %0d roll %0d", $time,
					pitch_angle, roll_angle);
				errors++;
			end else begin
				want = angles_due.pop_front();
				words_out++;
				if (pitch_angle !== want.pitch) begin
					$display("%0t: pitch expected %0d got %0d", $time, want.pitch,
						pitch_angle);
					errors++;
				end
				if (roll_angle !== want.roll) begin
					$display("%0t: roll expected %0d got %0d", $time, want.roll,
						roll_angle);
					errors++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run limit reached, %0d words pending", $time, angles_due.size());
		$display("tb: failure");
		$finish;
	end

	initial begin
		int pct [3];
		pct = '{0, 50, 13};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++)
			send_word(directed_rows[r].x, directed_rows[r].y, directed_rows[r].z,
				directed_rows[r].typed, directed_rows[r].angles);
		drain_pipe();

		for (int p = 0; p < 3; p++) begin
			for (int n = 0; n < RAND_WORDS / 3; n++)
				send_random(pct[p]);
			drain_pipe();
		end

		start <= 1'b0;
		while (angles_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		$display("tb: %0d words sent, %0d checked: directed table, then random words",
			words_in, words_out);
		$display("tb: sender idle rates 0, 50 and 13 per cent, pipe drained between phases");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
